// ===== rtl/jacobi_laplace_grid_solver_defines.svh =====
// Assertion macros for the Laplace grid solver RTL.
// No dependencies; included by jacobi_laplace_grid_solver.sv, which carries the concurrent checks.
`ifndef JACOBI_LAPLACE_GRID_SOLVER_DEFINES_SVH
`define JACOBI_LAPLACE_GRID_SOLVER_DEFINES_SVH

`ifndef SYNTH
`define JLS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jls same-cycle check failed");
`define JLS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jls next-cycle check failed");
`else
`define JLS_ASSERT_IMP(name, clk, rst, ante, cons)
`define JLS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/jls_pkg.sv =====
// Package for the Laplace grid solver: widths, fixed-point constants, codes and types.
// No dependencies; imported by jls_div and jacobi_laplace_grid_solver.
package jls_pkg;

   localparam int VAL_W     = 29;
   localparam int ITER_W    = 20;
   localparam int GS_W      = 8;
   localparam int QW        = 28;
   localparam int DIV_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [VAL_W-1:0]  VAL_MAX    = '1;
   localparam logic [VAL_W-1:0]  TEN_Q      = 29'd167772160;
   localparam logic [VAL_W-1:0]  TWENTY_Q   = 29'd335544320;
   localparam logic [QW-1:0]     SPAN_Q     = 28'd167772160;
   localparam logic [ITER_W-1:0] ITER_CAP   = 20'd1000000;
   localparam logic [VAL_W-1:0]  PREC_FLOOR = 29'd17;
   localparam logic [6:0]        CHECK_LAST = 7'd99;

   localparam logic CMD_RUN  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ITER_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRECISION  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FILL,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_READ,
      ST_RDATA,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             done;
      logic [QW-1:0]    quot;
      logic [DIV_W-1:0] rem;
   } div_result_type;

endpackage

// ===== rtl/jacobi_laplace_grid_solver.sv =====
// Jacobi Laplace solver on a square grid of Q5.24 cells, kept in two ping-pong RAMs
// with registered read data. A run beat runs the edge-step divider, builds the fresh
// grid at the clamped grid size into both RAMs, then sweeps until it stops; each interior
// cell of a sweep needs five reads through the single RAM read port. One beat is in work
// at a time, and a finished result waits in the output register. No clearing pass is
// needed after reset: cells outside the last run's grid, or before any run, read as zero.
`include "jacobi_laplace_grid_solver_defines.svh"

module jacobi_laplace_grid_solver import jls_pkg::*; #(
   parameter int MAX_SIZE = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [6:0]           req_row,
   input  logic [6:0]           req_col,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VAL_W-1:0]     rsp_cell_value,
   output logic [ITER_W-1:0]    rsp_iterations_done,
   output logic [VAL_W-1:0]     rsp_final_error,
   output logic                 rsp_out_of_range,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wdata
);

   localparam int CW    = $clog2(MAX_SIZE);
   localparam int NW    = $clog2(MAX_SIZE + 1);
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;

   localparam logic [2:0] PH_UP     = 3'd0;
   localparam logic [2:0] PH_LEFT   = 3'd1;
   localparam logic [2:0] PH_CENTER = 3'd2;
   localparam logic [2:0] PH_RIGHT  = 3'd3;
   localparam logic [2:0] PH_DOWN   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // Configuration registers.
   logic [GS_W-1:0]   grid_size_ff;
   logic [ITER_W-1:0] limit_ff;
   logic [VAL_W-1:0]  precision_ff;

   // Control and run state.
   state_type         state_ff, state_in;
   logic              rsp_valid_ff;
   logic              ran_ff;
   logic              cur_ff;
   logic [NW-1:0]     n_ff;
   logic [NW-1:0]     d_ff;
   logic [ITER_W-1:0] lim_ff;
   logic [VAL_W-1:0]  prec_run_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [6:0]        mod_ff;
   logic [VAL_W-1:0]  err_ff;
   logic              measured_ff;
   logic [ITER_W-1:0] sweep_count_ff;
   logic [VAL_W-1:0]  last_error_ff;

   // Datapath.
   logic [CW-1:0]     r_ff, c_ff;
   logic [2:0]        phase_ff;
   logic [QW-1:0]     qk_ff, qc_ff, qr_ff;
   logic [DIV_W-1:0]  rk_ff, rc_ff, rr_ff;
   logic [30:0]       sum_ff;
   logic [VAL_W-1:0]  center_ff;
   logic [VAL_W-1:0]  maxd_ff;
   logic [CW-1:0]     rd_row_ff, rd_col_ff;
   logic              zero_ff;
   logic              oor_ff;
   logic [VAL_W-1:0]  cell_ff;
   logic [VAL_W-1:0]  rsp_cell_ff;
   logic [ITER_W-1:0] rsp_iter_ff;
   logic [VAL_W-1:0]  rsp_err_ff;
   logic              rsp_oor_ff;

   // Grid memories.
   logic [VAL_W-1:0]  grid0_ff [DEPTH];
   logic [VAL_W-1:0]  grid1_ff [DEPTH];
   logic [VAL_W-1:0]  rdata0_ff, rdata1_ff;

   logic              we0, we1;
   logic [AW-1:0]     waddr, raddr;
   logic [VAL_W-1:0]  wdata;

   logic              div_start;
   div_result_type    div_res;

   logic [NW-1:0]     eff_n;
   logic [ITER_W-1:0] lim_c;
   logic [VAL_W-1:0]  prec_c;
   logic              req_accept, slot_free;
   logic              in_range, in_run;
   logic [DIV_W-1:0]  d_div, h_div;
   logic [NW-1:0]     n_last, n_inner;
   logic              col_last, row_last, col_inner_last, row_inner_last;
   logic              size_two;
   logic [QW+DIV_W-1:0] col_step, row_step;
   logic [VAL_W-1:0]  fill_val;
   logic [VAL_W-1:0]  rd;
   logic [30:0]       total;
   logic [VAL_W-1:0]  avg, diff;
   logic              meas_now, meas_any, stop;
   logic [VAL_W-1:0]  err_new, sat_err;
   logic [ITER_W-1:0] iter_nx;
   logic              fill_end, sweep_cell_end;

   function automatic logic [QW+DIV_W-1:0] step_acc(
      input logic [QW-1:0]    q,
      input logic [DIV_W-1:0] r,
      input logic [QW-1:0]    qk,
      input logic [DIV_W-1:0] rk,
      input logic [DIV_W-1:0] d
   );
      logic [DIV_W:0]   s;
      logic [QW-1:0]    qn;
      logic [DIV_W-1:0] rn;
      s = {1'b0, r} + {1'b0, rk};
      if (s >= {1'b0, d}) begin
         rn = DIV_W'(s - {1'b0, d});
         qn = q + qk + QW'(1);
      end else begin
         rn = s[DIV_W-1:0];
         qn = q + qk;
      end
      return {qn, rn};
   endfunction

   jls_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (DIV_W'(eff_n - NW'(1))),
      .result  (div_res)
   );

   // Clamped views of the configuration.
   always_comb begin
      if (grid_size_ff < 8'd2) begin
         eff_n = NW'(2);
      end else if (32'(grid_size_ff) > MAX_SIZE) begin
         eff_n = NW'(MAX_SIZE);
      end else begin
         eff_n = NW'(grid_size_ff);
      end
   end

   assign lim_c  = (limit_ff > ITER_CAP) ? ITER_CAP : limit_ff;
   assign prec_c = (precision_ff < PREC_FLOOR) ? PREC_FLOOR : precision_ff;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign in_range = (32'(req_row) < 32'(eff_n)) && (32'(req_col) < 32'(eff_n));
   assign in_run   = ran_ff && (32'(req_row) < 32'(n_ff)) && (32'(req_col) < 32'(n_ff));

   assign d_div    = DIV_W'(d_ff);
   assign h_div    = DIV_W'(d_ff >> 1);
   assign n_last   = n_ff - NW'(1);
   assign n_inner  = n_ff - NW'(2);
   assign size_two = n_ff == NW'(2);

   assign col_last       = NW'(c_ff) == n_last;
   assign row_last       = NW'(r_ff) == n_last;
   assign col_inner_last = NW'(c_ff) == n_inner;
   assign row_inner_last = NW'(r_ff) == n_inner;

   // Edge accumulators keep round(i*10/(n-1)) exactly as quotient plus remainder.
   assign col_step = step_acc(qc_ff, rc_ff, qk_ff, rk_ff, d_div);
   assign row_step = step_acc(qr_ff, rr_ff, qk_ff, rk_ff, d_div);

   always_comb begin
      if (r_ff == '0) begin
         fill_val = TEN_Q + VAL_W'(qc_ff);
      end else if (c_ff == '0) begin
         fill_val = TEN_Q + VAL_W'(qr_ff);
      end else if (col_last) begin
         fill_val = TWENTY_Q + VAL_W'(qr_ff);
      end else if (row_last) begin
         fill_val = TWENTY_Q + VAL_W'(qc_ff);
      end else begin
         fill_val = '0;
      end
   end

   assign fill_end = row_last && col_last;

   // Stencil arithmetic on the source bank.
   assign rd    = cur_ff ? rdata1_ff : rdata0_ff;
   assign total = sum_ff + {2'b00, rd};
   assign avg   = VAL_W'((total + 31'd2) >> 2);
   assign diff  = (avg > center_ff) ? (avg - center_ff) : (center_ff - avg);

   assign sweep_cell_end = (phase_ff == PH_DONE) && col_inner_last && row_inner_last;

   assign iter_nx  = iter_ff + ITER_W'(1);
   assign meas_now = (mod_ff == 7'd0) || (iter_nx == lim_ff);
   assign err_new  = meas_now ? maxd_ff : err_ff;
   assign meas_any = measured_ff || meas_now;
   assign stop     = (meas_any && (err_new <= prec_run_ff)) || (iter_nx >= lim_ff);
   assign sat_err  = (prec_run_ff == VAL_MAX) ? VAL_MAX : prec_run_ff + VAL_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_cmd == CMD_RUN) ? ST_DIV : ST_READ;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (fill_end) begin
               if (lim_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = size_two ? ST_SWEEP_END : ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_cell_end) begin
               state_in = ST_SWEEP_END;
            end
         end
         ST_SWEEP_END: begin
            if (stop) begin
               state_in = ST_RESP;
            end else begin
               state_in = size_two ? ST_SWEEP_END : ST_SWEEP;
            end
         end
         ST_READ:  state_in = ST_RDATA;
         ST_RDATA: state_in = ST_RESP;
         ST_RESP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory and divider controls.
   always_comb begin
      div_start = 1'b0;
      we0       = 1'b0;
      we1       = 1'b0;
      waddr     = {r_ff, c_ff};
      wdata     = fill_val;
      raddr     = {r_ff, c_ff};
      case (state_ff)
         ST_IDLE: begin
            div_start = req_accept && (req_cmd == CMD_RUN);
         end
         ST_FILL: begin
            we0 = 1'b1;
            we1 = 1'b1;
         end
         ST_SWEEP: begin
            case (phase_ff)
               PH_UP:    raddr = {r_ff - CW'(1), c_ff};
               PH_LEFT:  raddr = {r_ff, c_ff - CW'(1)};
               PH_RIGHT: raddr = {r_ff, c_ff + CW'(1)};
               PH_DOWN:  raddr = {r_ff + CW'(1), c_ff};
               default:  raddr = {r_ff, c_ff};
            endcase
            if (phase_ff == PH_DONE) begin
               we0   = cur_ff;
               we1   = !cur_ff;
               wdata = avg;
            end
         end
         ST_READ: begin
            raddr = {rd_row_ff, rd_col_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         grid0_ff[waddr] <= wdata;
      end
      rdata0_ff <= grid0_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         grid1_ff[waddr] <= wdata;
      end
      rdata1_ff <= grid1_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         ran_ff         <= 1'b0;
         cur_ff         <= 1'b0;
         sweep_count_ff <= '0;
         last_error_ff  <= '0;
         grid_size_ff   <= 8'd128;
         limit_ff       <= ITER_CAP;
         precision_ff   <= PREC_FLOOR;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               REG_GRID_SIZE:  grid_size_ff <= csr_wdata[GS_W-1:0];
               REG_ITER_LIMIT: limit_ff     <= csr_wdata[ITER_W-1:0];
               REG_PRECISION:  precision_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (state_ff == ST_RESP && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_cell_ff  <= cell_ff;
            rsp_iter_ff  <= sweep_count_ff;
            rsp_err_ff   <= last_error_ff;
            rsp_oor_ff   <= oor_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_cmd == CMD_RUN) begin
                     ran_ff      <= 1'b1;
                     n_ff        <= eff_n;
                     d_ff        <= eff_n - NW'(1);
                     lim_ff      <= lim_c;
                     prec_run_ff <= prec_c;
                     iter_ff     <= '0;
                     mod_ff      <= '0;
                     err_ff      <= '0;
                     measured_ff <= 1'b0;
                     cell_ff     <= '0;
                     oor_ff      <= 1'b0;
                  end else begin
                     rd_row_ff <= CW'(req_row);
                     rd_col_ff <= CW'(req_col);
                     oor_ff    <= !in_range;
                     zero_ff   <= !(in_range && in_run);
                  end
               end
            end
            ST_DIV: begin
               if (div_res.done) begin
                  qk_ff <= div_res.quot;
                  rk_ff <= div_res.rem;
                  r_ff  <= '0;
                  c_ff  <= '0;
                  qc_ff <= '0;
                  rc_ff <= h_div;
                  qr_ff <= '0;
                  rr_ff <= h_div;
               end
            end
            ST_FILL: begin
               if (fill_end) begin
                  if (lim_ff == '0) begin
                     sweep_count_ff <= '0;
                     last_error_ff  <= sat_err;
                  end
                  r_ff     <= CW'(1);
                  c_ff     <= CW'(1);
                  phase_ff <= PH_UP;
                  maxd_ff  <= '0;
               end else if (col_last) begin
                  c_ff           <= '0;
                  r_ff           <= r_ff + CW'(1);
                  qc_ff          <= '0;
                  rc_ff          <= h_div;
                  {qr_ff, rr_ff} <= row_step;
               end else begin
                  c_ff           <= c_ff + CW'(1);
                  {qc_ff, rc_ff} <= col_step;
               end
            end
            ST_SWEEP: begin
               case (phase_ff)
                  PH_LEFT:   sum_ff    <= {2'b00, rd};
                  PH_CENTER: sum_ff    <= total;
                  PH_RIGHT:  center_ff <= rd;
                  PH_DOWN:   sum_ff    <= total;
                  default: begin
                  end
               endcase
               if (phase_ff == PH_DONE) begin
                  phase_ff <= PH_UP;
                  if (diff > maxd_ff) begin
                     maxd_ff <= diff;
                  end
                  if (col_inner_last) begin
                     c_ff <= CW'(1);
                     r_ff <= r_ff + CW'(1);
                  end else begin
                     c_ff <= c_ff + CW'(1);
                  end
               end else begin
                  phase_ff <= phase_ff + 3'd1;
               end
            end
            ST_SWEEP_END: begin
               cur_ff      <= !cur_ff;
               iter_ff     <= iter_nx;
               mod_ff      <= (mod_ff == CHECK_LAST) ? 7'd0 : mod_ff + 7'd1;
               err_ff      <= err_new;
               measured_ff <= meas_any;
               r_ff        <= CW'(1);
               c_ff        <= CW'(1);
               phase_ff    <= PH_UP;
               maxd_ff     <= '0;
               if (stop) begin
                  sweep_count_ff <= iter_nx;
                  last_error_ff  <= err_new;
               end
            end
            ST_RDATA: begin
               cell_ff <= zero_ff ? '0 : rd;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_cell_ff;
   assign rsp_iterations_done = rsp_iter_ff;
   assign rsp_final_error     = rsp_err_ff;
   assign rsp_out_of_range    = rsp_oor_ff;

   // The stencil never writes a border cell.
   `JLS_ASSERT_IMP(a_no_border_write, clock, reset, (state_ff == ST_SWEEP && phase_ff == PH_DONE), (r_ff != '0 && c_ff != '0 && !col_last && !row_last))
   // A sweep is only finished while the run is still under its limit.
   `JLS_ASSERT_IMP(a_iter_below_limit, clock, reset, (state_ff == ST_SWEEP_END), (iter_ff < lim_ff))
   // The edge-step remainder is a proper remainder.
   `JLS_ASSERT_IMP(a_div_rem, clock, reset, (state_ff == ST_DIV && div_res.done), (div_res.rem < d_div))
   // Finishing a sweep flips the bank that holds the current grid.
   `JLS_ASSERT_NEXT(a_bank_flip, clock, reset, (state_ff == ST_SWEEP_END), (cur_ff != $past(cur_ff)))

endmodule

// ===== rtl/jls_div.sv =====
// Restoring divider of the constant edge span (10.0 in Q4.24) by the grid step count.
// Depends on jls_pkg; one quotient bit per cycle.
module jls_div import jls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] divisor,
   output div_result_type   result
);

   localparam logic [4:0] LAST_BIT = 5'(QW - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [4:0]       count_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [QW-1:0]    quot_ff;

   logic [4:0]       bit_idx;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign bit_idx = LAST_BIT - count_ff;
   assign trial   = {rem_ff, SPAN_Q[bit_idx]};
   assign fits    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= '0;
         rem_ff   <= '0;
         quot_ff  <= '0;
         dvs_ff   <= divisor;
      end else if (busy_ff) begin
         rem_ff   <= fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         quot_ff  <= {quot_ff[QW-2:0], fits};
         count_ff <= count_ff + 5'd1;
         if (count_ff == LAST_BIT) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;
   assign result.rem  = rem_ff;

endmodule
